// ===== rtl/text_console_char_engine_unit_macros.svh =====
// assertion helpers, expect clk and rst in scope
`ifndef TEXT_CONSOLE_CHAR_ENGINE_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define TCCE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCCE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcce_pkg.sv =====
package tcce_pkg;

  // screen geometry
  localparam int ROWS  = 25;
  localparam int COLS  = 80;
  localparam int CELLS = ROWS * COLS;

  // field widths
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = $clog2(CELLS);

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0f;

  // derived addresses and limits
  localparam logic [ADDR_W-1:0] COLS_A        = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SHIFT_END     = ADDR_W'(CELLS - COLS);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLS);
  localparam logic [ROW_W-1:0]  ROW_LAST      = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST      = COL_W'(COLS - 1);

  // memory request from the sequencer
  typedef struct packed {
    logic              char_we;
    logic              attr_we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wchar;
    logic [ATTR_W-1:0] wattr;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // registered read data
  typedef struct packed {
    logic [CHAR_W-1:0] rchar;
    logic [ATTR_W-1:0] rattr;
  } mem_rsp_t;

endpackage

// ===== rtl/tcce_intf.sv =====
interface tcce_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [tcce_pkg::FUNC_W-1:0] func;
  logic [tcce_pkg::CHAR_W-1:0] char_code;
  logic [tcce_pkg::ROW_W-1:0]  cell_row;
  logic [tcce_pkg::COL_W-1:0]  cell_col;

  modport source (output valid, func, char_code, cell_row, cell_col, input ready);
  modport sink (input valid, func, char_code, cell_row, cell_col, output ready);
endinterface

interface tcce_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tcce_pkg::ROW_W-1:0]  cursor_row;
  logic [tcce_pkg::COL_W-1:0]  cursor_col;
  logic [tcce_pkg::CHAR_W-1:0] cell_char;
  logic [tcce_pkg::ATTR_W-1:0] cell_attr;
  logic                        scrolled;

  modport source (output valid, cursor_row, cursor_col, cell_char, cell_attr, scrolled,
                  input ready);
  modport sink (input valid, cursor_row, cursor_col, cell_char, cell_attr, scrolled,
                output ready);
endinterface

// ===== rtl/tcce_ram.sv =====
module tcce_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tcce_seq.sv =====
module tcce_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tcce_pkg::ATTR_W-1:0] text_attribute,
  output tcce_pkg::mem_req_t          mreq,
  input  tcce_pkg::mem_rsp_t          mrsp,
  tcce_cmd_if.sink                    cmd,
  tcce_rsp_if.source                  rsp
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RDATA  = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]                  state;
  logic [tcce_pkg::ADDR_W-1:0] ptr;
  logic [tcce_pkg::ROW_W-1:0]  cur_row;
  logic [tcce_pkg::COL_W-1:0]  cur_col;
  logic [tcce_pkg::ADDR_W-1:0] cur_addr;
  logic [tcce_pkg::FUNC_W-1:0] op_func;
  logic [tcce_pkg::CHAR_W-1:0] op_char;
  logic [tcce_pkg::ADDR_W-1:0] rd_addr;
  logic                        rd_ok;
  logic [tcce_pkg::CHAR_W-1:0] res_char;
  logic [tcce_pkg::ATTR_W-1:0] res_attr;
  logic                        res_scr;
  logic                        out_valid;
  logic [tcce_pkg::ROW_W-1:0]  out_row;
  logic [tcce_pkg::COL_W-1:0]  out_col;
  logic [tcce_pkg::CHAR_W-1:0] out_char;
  logic [tcce_pkg::ATTR_W-1:0] out_attr;
  logic                        out_scr;

  logic                        in_range;
  logic [tcce_pkg::ADDR_W-1:0] rd_addr_next;
  logic [tcce_pkg::ADDR_W-1:0] ptr_inc;

  assign in_range = ({1'b0, cmd.cell_row} < (tcce_pkg::ROW_W + 1)'(tcce_pkg::ROWS)) &&
                    ({1'b0, cmd.cell_col} < (tcce_pkg::COL_W + 1)'(tcce_pkg::COLS));
  assign rd_addr_next = tcce_pkg::ADDR_W'(tcce_pkg::ADDR_W'(cmd.cell_row) * tcce_pkg::COLS_A
                        + tcce_pkg::ADDR_W'(cmd.cell_col));
  assign ptr_inc = ptr + tcce_pkg::ADDR_W'(1);

  assign cmd.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.cursor_row = out_row;
  assign rsp.cursor_col = out_col;
  assign rsp.cell_char  = out_char;
  assign rsp.cell_attr  = out_attr;
  assign rsp.scrolled   = out_scr;

  // memory port control
  always_comb begin
    mreq = '0;
    unique case (state)
      S_INIT: begin
        mreq.char_we = 1'b1;
        mreq.attr_we = 1'b1;
        mreq.waddr   = ptr;
        mreq.wchar   = tcce_pkg::SPACE_CODE;
        mreq.wattr   = '0;
      end
      S_EXEC: begin
        if (op_func == tcce_pkg::FUNC_PUT && op_char != tcce_pkg::NEWLINE_CODE) begin
          mreq.char_we = 1'b1;
          mreq.attr_we = 1'b1;
          mreq.waddr   = cur_addr;
          mreq.wchar   = op_char;
          mreq.wattr   = text_attribute;
        end
        // read cell, or prime the first row copy of a scroll
        mreq.raddr = (op_func == tcce_pkg::FUNC_READ) ? rd_addr : tcce_pkg::COLS_A;
      end
      S_SCROLL: begin
        mreq.waddr = ptr;
        if (ptr < tcce_pkg::SHIFT_END) begin
          mreq.char_we = 1'b1;
          mreq.attr_we = 1'b1;
          mreq.wchar   = mrsp.rchar;
          mreq.wattr   = mrsp.rattr;
        end else begin
          mreq.char_we = 1'b1;
          mreq.wchar   = tcce_pkg::SPACE_CODE;
        end
        // reads run one cell ahead of writes, always above them
        if (ptr_inc < tcce_pkg::SHIFT_END) begin
          mreq.raddr = tcce_pkg::ADDR_W'(ptr_inc + tcce_pkg::COLS_A);
        end
      end
      S_CLEAR: begin
        mreq.char_we = 1'b1;
        mreq.waddr   = ptr;
        mreq.wchar   = tcce_pkg::SPACE_CODE;
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      ptr       <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      cur_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // result register drains here unless a new word loads it in the same cycle
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (ptr == tcce_pkg::LAST_CELL) begin
            ptr   <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr_inc;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            op_func <= cmd.func;
            op_char <= cmd.char_code;
            rd_ok   <= in_range;
            rd_addr <= in_range ? rd_addr_next : '0;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_char <= '0;
          res_attr <= '0;
          res_scr  <= 1'b0;
          ptr      <= '0;
          unique case (op_func)
            tcce_pkg::FUNC_PUT: begin
              if (op_char == tcce_pkg::NEWLINE_CODE) begin
                if (cur_row == tcce_pkg::ROW_LAST) begin
                  state <= S_SCROLL;
                end else begin
                  cur_row  <= cur_row + tcce_pkg::ROW_W'(1);
                  cur_col  <= '0;
                  cur_addr <= tcce_pkg::ADDR_W'(cur_addr - tcce_pkg::ADDR_W'(cur_col)
                              + tcce_pkg::COLS_A);
                  state    <= S_DONE;
                end
              end else if (cur_addr == tcce_pkg::LAST_CELL) begin
                state <= S_SCROLL;
              end else begin
                cur_addr <= cur_addr + tcce_pkg::ADDR_W'(1);
                if (cur_col == tcce_pkg::COL_LAST) begin
                  cur_col <= '0;
                  cur_row <= cur_row + tcce_pkg::ROW_W'(1);
                end else begin
                  cur_col <= cur_col + tcce_pkg::COL_W'(1);
                end
                state <= S_DONE;
              end
            end
            tcce_pkg::FUNC_READ:  state <= S_RDATA;
            tcce_pkg::FUNC_CLEAR: state <= S_CLEAR;
            default:              state <= S_DONE;
          endcase
        end
        S_RDATA: begin
          if (rd_ok) begin
            res_char <= mrsp.rchar;
            res_attr <= mrsp.rattr;
          end
          state <= S_DONE;
        end
        S_SCROLL: begin
          ptr <= ptr_inc;
          if (ptr == tcce_pkg::LAST_CELL) begin
            cur_row  <= tcce_pkg::ROW_LAST;
            cur_col  <= '0;
            cur_addr <= tcce_pkg::LAST_ROW_BASE;
            res_scr  <= 1'b1;
            state    <= S_DONE;
          end
        end
        S_CLEAR: begin
          ptr <= ptr_inc;
          if (ptr == tcce_pkg::LAST_CELL) begin
            cur_row  <= '0;
            cur_col  <= '0;
            cur_addr <= '0;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_row   <= cur_row;
            out_col   <= cur_col;
            out_char  <= res_char;
            out_attr  <= res_attr;
            out_scr   <= res_scr;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/text_console_char_engine_unit.sv =====
// text console engine: a 25 x 80 screen of character/attribute cells held in two
// single-port-write, registered-read memories, plus a cursor kept as row, column
// and linear address. after reset a clearing pass writes spaces with attribute
// zero to all 2000 cells, during which no command word is taken (attribute
// writes are taken at any time). a put or a no-op passes through the exec and
// done states from accept to result, a read also through the read-data state
// that captures the registered memory read; a scroll or a clear walks every
// cell once, one per cycle. the sequencer works on one command at a time; the
// result register lets the next command in while a result word still waits
`include "text_console_char_engine_unit_macros.svh"

module text_console_char_engine_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tcce_pkg::ATTR_W-1:0] cfg_data,
  tcce_cmd_if.sink                    cmd,
  tcce_rsp_if.source                  rsp
);

  // attribute stored with each printed character
  logic [tcce_pkg::ATTR_W-1:0] text_attribute;

  tcce_pkg::mem_req_t mreq;
  tcce_pkg::mem_rsp_t mrsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tcce_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      text_attribute <= cfg_data;
    end
  end

  // character plane, cleared independently of attributes
  tcce_ram #(
    .DEPTH (tcce_pkg::CELLS),
    .WIDTH (tcce_pkg::CHAR_W)
  ) u_char_ram (
    .clk   (clk),
    .we    (mreq.char_we),
    .waddr (mreq.waddr),
    .wdata (mreq.wchar),
    .raddr (mreq.raddr),
    .rdata (mrsp.rchar)
  );

  // attribute plane
  tcce_ram #(
    .DEPTH (tcce_pkg::CELLS),
    .WIDTH (tcce_pkg::ATTR_W)
  ) u_attr_ram (
    .clk   (clk),
    .we    (mreq.attr_we),
    .waddr (mreq.waddr),
    .wdata (mreq.wattr),
    .raddr (mreq.raddr),
    .rdata (mrsp.rattr)
  );

  // command sequencer, cursor and result word
  tcce_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .text_attribute (text_attribute),
    .mreq           (mreq),
    .mrsp           (mrsp),
    .cmd            (cmd),
    .rsp            (rsp)
  );

  // cursor always on screen
  `TCCE_ASSERT_IMP(a_cursor_range, rsp.valid,
    (rsp.cursor_row <= tcce_pkg::ROW_LAST) && (rsp.cursor_col <= tcce_pkg::COL_LAST),
    "cursor off screen")
  // a scroll leaves the cursor at the start of the last row
  `TCCE_ASSERT_IMP(a_scroll_home, rsp.valid && rsp.scrolled,
    (rsp.cursor_row == tcce_pkg::ROW_LAST) && (rsp.cursor_col == '0),
    "scroll cursor wrong")
  // a scrolling command never carries cell data
  `TCCE_ASSERT_IMP(a_scroll_no_cell, rsp.valid && rsp.scrolled,
    (rsp.cell_char == '0) && (rsp.cell_attr == '0), "cell data on scroll")
  // one command at a time
  `TCCE_ASSERT_NXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready,
    "accepted back to back")

endmodule
